### rtl/ssr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssr_pkg: shared types and constants for the sprite scanline renderer
// Colour type codes, pattern geometry and the record that the front end
// hands to the back end through the work queue.
// ----------------------------------------------------------------------------
package ssr_pkg;

    localparam int PIXELS_PER_ROW = 8;
    localparam int SLOTS          = 16;   // 8 pixels, each doubled at most
    localparam int QUEUE_DEPTH    = 4;
    localparam int QPTR_W         = $clog2(QUEUE_DEPTH);

    localparam logic [1:0] CTYPE_STANDARD = 2'd0;
    localparam logic [1:0] CTYPE_SPECTRA  = 2'd1;
    localparam logic [1:0] CTYPE_ULAPLUS  = 2'd2;

    localparam logic APB_REG_ENABLE = 1'b0;   // register index of sprite_enable

    typedef logic [PIXELS_PER_ROW-1:0][3:0] row_pixels_t;

    // One drawable sprite line: pixels already in screen order, plus the
    // set of write slots that actually produce a result.
    typedef struct packed {
        logic [15:0]       left_col;
        row_pixels_t       pixels;
        logic [SLOTS-1:0]  slot_mask;
        logic              zoom_x;
        logic [1:0]        ctype;
        logic [1:0]        group;
    } line_job_t;

endpackage

### rtl/ssr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssr_front: sprite classification
// Visibility tests, row selection with y-mirror/y-zoom, x-mirror, and the
// mask of write slots that are opaque and on screen.
// ----------------------------------------------------------------------------
module ssr_front #(
    parameter int VISIBLE_LINES = 192,
    parameter int LINE_WIDTH    = 256
) (
    input  logic               sprite_enable,
    input  logic [8:0]         scanline,
    input  logic [15:0]        left_col,
    input  logic [15:0]        top_line,
    input  logic [7:0]         attr_one,
    input  logic [7:0]         attr_two,
    input  logic               blink_phase,
    input  logic [63:0]        pattern_rows_01,
    input  logic [63:0]        pattern_rows_23,
    input  logic [63:0]        pattern_rows_45,
    input  logic [63:0]        pattern_rows_67,
    output logic               hit,
    output ssr_pkg::line_job_t job
);

    logic [15:0]               line16;
    logic [15:0]               offset;
    logic                      in_range;
    logic [2:0]                rowsel;
    logic [2:0]                row;
    logic [63:0]               row_pair;
    logic [31:0]               row_bits;
    ssr_pkg::row_pixels_t      pix;
    logic [ssr_pkg::SLOTS-1:0] mask;

    assign line16 = {7'd0, scanline};
    assign offset = line16 - top_line;

    always_comb begin
        in_range = (line16 >= top_line) && (offset[15:4] == 12'd0)
                   && (attr_one[4] || !offset[3]);
        rowsel = attr_one[4] ? offset[3:1] : offset[2:0];
        row    = attr_one[2] ? ~rowsel : rowsel;
    end

    always_comb begin
        case (row[2:1])
            2'd0:    row_pair = pattern_rows_01;
            2'd1:    row_pair = pattern_rows_23;
            2'd2:    row_pair = pattern_rows_45;
            default: row_pair = pattern_rows_67;
        endcase
        row_bits = row[0] ? row_pair[63:32] : row_pair[31:0];
    end

    // byte i holds pixels 2i (high nibble) and 2i+1 (low nibble)
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            if (attr_one[1]) begin
                pix[7-2*i] = row_bits[8*i+4 +: 4];
                pix[6-2*i] = row_bits[8*i +: 4];
            end else begin
                pix[2*i]   = row_bits[8*i+4 +: 4];
                pix[2*i+1] = row_bits[8*i +: 4];
            end
        end
    end

    always_comb begin
        logic [3:0]  slot;
        logic [2:0]  pidx;
        logic [16:0] col;
        for (int k = 0; k < ssr_pkg::SLOTS; k++) begin
            slot    = 4'(k);
            pidx    = attr_one[3] ? slot[3:1] : slot[2:0];
            col     = {1'b0, left_col} + 17'(k);
            mask[k] = (attr_one[3] || !slot[3]) && (pix[pidx] != 4'd0)
                      && (col < 17'(LINE_WIDTH));
        end
    end

    always_comb begin
        hit = sprite_enable && attr_one[0] && !(blink_phase && attr_one[5])
              && ({1'b0, scanline} < 10'(VISIBLE_LINES)) && in_range
              && (mask != '0);
        job.left_col  = left_col;
        job.pixels    = pix;
        job.slot_mask = mask;
        job.zoom_x    = attr_one[3];
        job.ctype     = attr_two[1:0];
        job.group     = attr_two[3:2];
    end

endmodule

### rtl/ssr_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssr_queue: job queue between front and back end
// Small register-file FIFO of line jobs; head is visible without a pop.
// ----------------------------------------------------------------------------
module ssr_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  ssr_pkg::line_job_t push_job,
    input  logic               pop,
    output ssr_pkg::line_job_t head_job,
    output logic               empty,
    output logic               full
);

    ssr_pkg::line_job_t              entry_reg [ssr_pkg::QUEUE_DEPTH];
    logic [ssr_pkg::QPTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [ssr_pkg::QPTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [ssr_pkg::QPTR_W:0]        count_reg, count_next;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == (ssr_pkg::QPTR_W+1)'(ssr_pkg::QUEUE_DEPTH));
    assign head_job = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

### rtl/ssr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssr_back: pixel write issue
// Walks the current job's slot mask lowest first, one write per cycle unless
// stalled, maps the colour and drives the registered result channel.
// ----------------------------------------------------------------------------
module ssr_back #(
    parameter int SPECTRA_BASE = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  ssr_pkg::line_job_t head_job,
    input  logic               queue_empty,
    output logic               pop,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [23:0]        m_tdata,
    output logic               m_tuser,
    output logic               m_tlast
);

    ssr_pkg::line_job_t        job_reg, job_next;
    logic [ssr_pkg::SLOTS-1:0] mask_reg, mask_next;
    logic                      valid_reg, valid_next;
    logic [7:0]                column_reg, column_next;
    logic [15:0]               colour_reg, colour_next;
    logic                      lookup_reg, lookup_next;
    logic                      last_reg, last_next;

    logic                      advance;
    logic                      emit;
    logic [ssr_pkg::SLOTS-1:0] low_bit;
    logic [ssr_pkg::SLOTS-1:0] mask_left;
    logic [3:0]                slot;
    logic [2:0]                pidx;
    logic [3:0]                pixel;

    assign advance = !valid_reg || m_tready;
    assign emit    = advance && (mask_reg != '0);
    assign low_bit = mask_reg & (~mask_reg + 1'b1);
    assign mask_left = emit ? (mask_reg & ~low_bit) : mask_reg;

    always_comb begin
        slot = 4'd0;
        for (int k = 0; k < ssr_pkg::SLOTS; k++) begin
            if (low_bit[k]) begin
                slot = slot | 4'(k);
            end
        end
        pidx  = job_reg.zoom_x ? slot[3:1] : slot[2:0];
        pixel = job_reg.pixels[pidx];
    end

    always_comb begin
        pop         = (mask_left == '0) && !queue_empty;
        mask_next   = pop ? head_job.slot_mask : mask_left;
        job_next    = pop ? head_job : job_reg;
        valid_next  = emit ? 1'b1 : (valid_reg && !m_tready);
        column_next = column_reg;
        colour_next = colour_reg;
        lookup_next = lookup_reg;
        last_next   = last_reg;
        if (emit) begin
            column_next = job_reg.left_col[7:0] + {4'd0, slot};
            colour_next = {12'd0, pixel} + {10'd0, job_reg.group, 4'd0};
            lookup_next = 1'b0;
            case (job_reg.ctype)
                ssr_pkg::CTYPE_SPECTRA: begin
                    colour_next = colour_next + 16'(SPECTRA_BASE);
                end
                ssr_pkg::CTYPE_ULAPLUS: begin
                    lookup_next = 1'b1;
                end
                default: begin
                    colour_next = {12'd0, pixel};
                end
            endcase
            last_next = ((mask_reg & ~low_bit) == '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg  <= '0;
            valid_reg <= 1'b0;
        end else begin
            mask_reg  <= mask_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        job_reg    <= job_next;
        column_reg <= column_next;
        colour_reg <= colour_next;
        lookup_reg <= lookup_next;
        last_reg   <= last_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {colour_reg, column_reg};
    assign m_tuser  = lookup_reg;
    assign m_tlast  = last_reg;

endmodule

### rtl/sprite_scanline_renderer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprite_scanline_renderer_unit: one sprite line to pixel writes
// Classifies 8x8 4bpp sprite records against the scanline and issues one
// pixel write per opaque, on-screen pixel.
// ----------------------------------------------------------------------------
// A sprite record is taken on every cycle that the job queue has room; the
// front end classifies it in that same cycle and sprites that draw nothing
// are dropped without using the queue. The back end issues one pixel write
// per cycle while m_tready allows, up to 16 for a sprite with x-zoom, and
// the four-entry job queue lets input keep flowing while it drains. Results
// pass through the queue and the back end's job, mask and output registers.
// Writes appear left to right with m_tlast on the last write of a sprite;
// m_tuser flags a ULAplus palette index.
module sprite_scanline_renderer_unit #(
    parameter int SPECTRA_BASE  = 16,
    parameter int VISIBLE_LINES = 192,
    parameter int LINE_WIDTH    = 256
) (
    input  logic         aclk,
    input  logic         aresetn,
    // scanline, left_col, top_line, attr_one, attr_two, blink_phase,
    // pattern_rows_01, pattern_rows_23, pattern_rows_45, pattern_rows_67, pad
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [319:0] s_tdata,
    // pixel_column, colour_value
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [23:0]  m_tdata,
    // needs_palette_lookup
    output logic         m_tuser,
    output logic         m_tlast,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    logic               enable_reg, enable_next;
    logic               hit;
    logic               push;
    logic               pop;
    logic               q_empty;
    logic               q_full;
    ssr_pkg::line_job_t front_job;
    ssr_pkg::line_job_t head_job;

    assign pready = 1'b1;

    always_comb begin
        enable_next = enable_reg;
        if (psel && penable && pwrite && (paddr[2] == ssr_pkg::APB_REG_ENABLE)) begin
            enable_next = pwdata[0];
        end
        prdata = (paddr[2] == ssr_pkg::APB_REG_ENABLE) ? {31'd0, enable_reg} : 32'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg <= 1'b0;
        end else begin
            enable_reg <= enable_next;
        end
    end

    assign s_tready = !q_full;
    assign push     = s_tvalid && s_tready && hit;

    ssr_front #(
        .VISIBLE_LINES (VISIBLE_LINES),
        .LINE_WIDTH    (LINE_WIDTH)
    ) u_front (
        .sprite_enable   (enable_reg),
        .scanline        (s_tdata[8:0]),
        .left_col        (s_tdata[24:9]),
        .top_line        (s_tdata[40:25]),
        .attr_one        (s_tdata[48:41]),
        .attr_two        (s_tdata[56:49]),
        .blink_phase     (s_tdata[57]),
        .pattern_rows_01 (s_tdata[121:58]),
        .pattern_rows_23 (s_tdata[185:122]),
        .pattern_rows_45 (s_tdata[249:186]),
        .pattern_rows_67 (s_tdata[313:250]),
        .hit             (hit),
        .job             (front_job)
    );

    ssr_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (front_job),
        .pop      (pop),
        .head_job (head_job),
        .empty    (q_empty),
        .full     (q_full)
    );

    ssr_back #(
        .SPECTRA_BASE (SPECTRA_BASE)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .head_job    (head_job),
        .queue_empty (q_empty),
        .pop         (pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule
